>>> sv/pdfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse-distance frame receiver package
// Shared types and codes: decoder phases, result kinds, register indexes.
// ----------------------------------------------------------------------------
package pdfr_pkg;

    localparam int DUR_W  = 16;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 3;
    localparam int POS_W  = 4;
    localparam int PH_W   = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic [DUR_W-1:0]  t_dur;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CNT_W-1:0]  t_bit_cnt;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [PH_W-1:0]   t_phase;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Decoder phases (also reported as the error phase)
    localparam t_phase PH_LEAD_PULSE = 2'd0;
    localparam t_phase PH_LEAD_SPACE = 2'd1;
    localparam t_phase PH_BIT_PULSE  = 2'd2;
    localparam t_phase PH_BIT_SPACE  = 2'd3;

    // Result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Configuration register indexes
    localparam t_cfg_idx REG_LEAD_PULSE = 3'd0;
    localparam t_cfg_idx REG_LEAD_SPACE = 3'd1;
    localparam t_cfg_idx REG_BIT_PULSE  = 3'd2;
    localparam t_cfg_idx REG_ONE_SPACE  = 3'd3;
    localparam t_cfg_idx REG_TOLERANCE  = 3'd4;

    // Register reset values
    localparam t_dur RST_LEAD_PULSE = 16'd9000;
    localparam t_dur RST_LEAD_SPACE = 16'd5000;
    localparam t_dur RST_BIT_PULSE  = 16'd1000;
    localparam t_dur RST_ONE_SPACE  = 16'd3000;
    localparam t_dur RST_TOLERANCE  = 16'd300;

    // A first byte below this threshold marks an inverted frame
    localparam t_byte INVERT_LIMIT = 8'h40;
    localparam t_byte BYTE_ONES    = 8'hFF;

    // Result item
    typedef struct packed {
        logic   kind;
        t_byte  data_byte;
        t_pos   byte_index;
        logic   frame_end;
        logic   checksum_ok;
        logic   inverted;
        t_phase error_phase;
    } t_result;

endpackage

>>> sv/pdfr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge request channel
// Valid/ready channel carrying one line edge: new level and elapsed time.
// ----------------------------------------------------------------------------
interface pdfr_in_if;
    logic              valid;
    logic              ready;
    logic              level;
    pdfr_pkg::t_dur    elapsed_us;

    modport source (output valid, output level, output elapsed_us, input ready);
    modport sink   (input valid, input level, input elapsed_us, output ready);
endinterface

>>> sv/pdfr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result request channel
// Valid/ready channel carrying one decoded byte or one framing error.
// ----------------------------------------------------------------------------
interface pdfr_out_if;
    logic              valid;
    logic              ready;
    logic              kind;
    pdfr_pkg::t_byte   data_byte;
    pdfr_pkg::t_pos    byte_index;
    logic              frame_end;
    logic              checksum_ok;
    logic              inverted;
    pdfr_pkg::t_phase  error_phase;

    modport source (
        output valid, output kind, output data_byte, output byte_index,
        output frame_end, output checksum_ok, output inverted, output error_phase,
        input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input byte_index,
        input frame_end, input checksum_ok, input inverted, input error_phase,
        output ready
    );
endinterface

>>> sv/pulse_distance_frame_receiver.sv
`timescale 1ns / 1ps
// Pipeline: an accepted edge request is held in the input register; its result,
//   if any, is registered in the result register, where it can be taken.
// Throughput: one edge request per cycle; the decode step sits between the
//   input register and the result register and updates the state in one pass.
//   A result that waits for its consumer stalls the next edge request.
// Reset (synchronous, active low): timing registers return to their defaults,
//   the decoder waits for a lead pulse, and both pipeline registers empty.
// ----------------------------------------------------------------------------
// Pulse-distance frame receiver
// Decodes edge timings into bytes, handles frame inversion and checksum, and
// reports framing errors.
// ----------------------------------------------------------------------------
module pulse_distance_frame_receiver #(
    parameter int FRAME_BYTES = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  pdfr_pkg::t_cfg_idx    i_cfg_idx,
    input  pdfr_pkg::t_dur        i_cfg_data,
    pdfr_in_if.sink               i_edge,
    pdfr_out_if.source            o_res
);

    localparam pdfr_pkg::t_pos LAST_POS = pdfr_pkg::POS_W'(FRAME_BYTES - 1);

    // Configuration registers
    pdfr_pkg::t_dur r_lead_pulse, r_lead_space, r_bit_pulse, r_one_space, r_tol;

    // Input register
    logic           r_in_valid;
    logic           r_level;
    pdfr_pkg::t_dur r_elapsed;

    // Decoder state
    pdfr_pkg::t_phase   r_phase, n_phase;
    pdfr_pkg::t_byte    r_shift, n_shift;
    pdfr_pkg::t_bit_cnt r_cnt, n_cnt;
    pdfr_pkg::t_pos     r_pos, n_pos;
    logic               r_invert, n_invert;
    pdfr_pkg::t_byte    r_sum, n_sum;

    // Result register
    logic              r_out_valid;
    logic              n_has_res;
    pdfr_pkg::t_result r_res, n_res;

    logic advance;
    logic in_ready;

    assign advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || advance;
    assign i_edge.ready = in_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pulse <= pdfr_pkg::RST_LEAD_PULSE;
            r_lead_space <= pdfr_pkg::RST_LEAD_SPACE;
            r_bit_pulse  <= pdfr_pkg::RST_BIT_PULSE;
            r_one_space  <= pdfr_pkg::RST_ONE_SPACE;
            r_tol        <= pdfr_pkg::RST_TOLERANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pdfr_pkg::REG_LEAD_PULSE: r_lead_pulse <= i_cfg_data;
                pdfr_pkg::REG_LEAD_SPACE: r_lead_space <= i_cfg_data;
                pdfr_pkg::REG_BIT_PULSE:  r_bit_pulse  <= i_cfg_data;
                pdfr_pkg::REG_ONE_SPACE:  r_one_space  <= i_cfg_data;
                pdfr_pkg::REG_TOLERANCE:  r_tol        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the edge request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_edge.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_edge.valid) begin
            r_level   <= i_edge.level;
            r_elapsed <= i_edge.elapsed_us;
        end
    end

    // Match a duration against a reference within the tolerance
    function automatic logic near_ref(pdfr_pkg::t_dur d, pdfr_pkg::t_dur r,
                                      pdfr_pkg::t_dur tol);
        pdfr_pkg::t_dur diff;
        diff = (d >= r) ? (d - r) : (r - d);
        return diff <= tol;
    endfunction

    // Decode one edge
    always_comb begin
        logic               gap;
        pdfr_pkg::t_phase   ph;
        pdfr_pkg::t_byte    shift;
        pdfr_pkg::t_bit_cnt cnt;
        pdfr_pkg::t_pos     pos;
        pdfr_pkg::t_byte    raw;
        pdfr_pkg::t_byte    data;
        logic               inv;
        logic               last;
        logic               byte_done;
        logic               err;
        pdfr_pkg::t_phase   err_ph;

        gap = {1'b0, r_elapsed} > ({1'b0, r_lead_space} + {1'b0, r_tol});
        ph    = gap ? pdfr_pkg::PH_LEAD_PULSE : r_phase;
        shift = gap ? '0 : r_shift;
        cnt   = gap ? '0 : r_cnt;
        pos   = gap ? '0 : r_pos;

        n_phase   = ph;
        n_shift   = shift;
        n_cnt     = cnt;
        n_pos     = pos;
        n_invert  = r_invert;
        n_sum     = r_sum;
        n_has_res = 1'b0;
        n_res     = '0;
        byte_done = 1'b0;
        err       = 1'b0;
        err_ph    = pdfr_pkg::PH_LEAD_PULSE;
        raw       = shift;

        case (ph)
            pdfr_pkg::PH_LEAD_PULSE: begin
                if (!r_level && near_ref(r_elapsed, r_lead_pulse, r_tol)) begin
                    n_phase = pdfr_pkg::PH_LEAD_SPACE;
                end
            end
            pdfr_pkg::PH_LEAD_SPACE: begin
                if (r_level && near_ref(r_elapsed, r_lead_space, r_tol)) begin
                    n_phase = pdfr_pkg::PH_BIT_PULSE;
                end else begin
                    err    = 1'b1;
                    err_ph = pdfr_pkg::PH_LEAD_SPACE;
                end
            end
            pdfr_pkg::PH_BIT_PULSE: begin
                if (!r_level && near_ref(r_elapsed, r_bit_pulse, r_tol)) begin
                    n_phase = pdfr_pkg::PH_BIT_SPACE;
                end else begin
                    err    = 1'b1;
                    err_ph = pdfr_pkg::PH_BIT_PULSE;
                end
            end
            default: begin
                if (!r_level) begin
                    err    = 1'b1;
                    err_ph = pdfr_pkg::PH_BIT_SPACE;
                end else begin
                    n_phase = pdfr_pkg::PH_BIT_PULSE;
                    if (near_ref(r_elapsed, r_one_space, r_tol)) begin
                        raw = shift | (pdfr_pkg::BYTE_W'(1) << cnt);
                    end
                    if (cnt != '1) begin
                        n_shift = raw;
                        n_cnt   = cnt + 1'b1;
                    end else begin
                        n_shift   = '0;
                        n_cnt     = '0;
                        byte_done = 1'b1;
                    end
                end
            end
        endcase

        // Finish a byte: inversion, checksum, frame position
        inv  = (pos == '0) ? (raw < pdfr_pkg::INVERT_LIMIT) : r_invert;
        data = inv ? (raw ^ pdfr_pkg::BYTE_ONES) : raw;
        last = pos >= LAST_POS;

        if (err) begin
            n_phase   = pdfr_pkg::PH_LEAD_PULSE;
            n_shift   = '0;
            n_cnt     = '0;
            n_pos     = '0;
            n_has_res = 1'b1;
            n_res.kind        = pdfr_pkg::KIND_ERROR;
            n_res.error_phase = err_ph;
        end else if (byte_done) begin
            n_invert  = inv;
            n_has_res = 1'b1;
            n_res.kind       = pdfr_pkg::KIND_BYTE;
            n_res.data_byte  = data;
            n_res.byte_index = pos;
            n_res.frame_end  = last;
            n_res.inverted   = inv;
            if (pos == '0) begin
                n_sum = '0;
            end else if (last) begin
                n_res.checksum_ok = (r_sum == data);
            end else begin
                n_sum = r_sum + data;
            end
            n_pos = last ? '0 : pos + 1'b1;
        end
    end

    // Advance decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pdfr_pkg::PH_LEAD_PULSE;
            r_shift  <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_invert <= 1'b0;
            r_sum    <= '0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_invert <= n_invert;
            r_sum    <= n_sum;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_has_res;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_has_res) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_res.kind;
    assign o_res.data_byte   = r_res.data_byte;
    assign o_res.byte_index  = r_res.byte_index;
    assign o_res.frame_end   = r_res.frame_end;
    assign o_res.checksum_ok = r_res.checksum_ok;
    assign o_res.inverted    = r_res.inverted;
    assign o_res.error_phase = r_res.error_phase;

endmodule

>>> sv/pdfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse-distance frame receiver checker
// Port-level checks on result items, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pdfr_checker #(
    parameter int FRAME_BYTES = 10
) (
    input logic i_clk,
    input logic i_rst_n,
    pdfr_out_if.source o_res
);

    localparam pdfr_pkg::t_pos LAST_POS = pdfr_pkg::POS_W'(FRAME_BYTES - 1);

    // Error results carry only the phase, and it is never the idle phase
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == pdfr_pkg::KIND_ERROR) |->
        (o_res.data_byte == '0 && o_res.byte_index == '0 && !o_res.frame_end &&
         !o_res.checksum_ok && !o_res.inverted &&
         o_res.error_phase != pdfr_pkg::PH_LEAD_PULSE))
        else $error("error result carries byte fields or idle phase");

    // Frame end marks exactly the last byte position
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == pdfr_pkg::KIND_BYTE) |->
        (o_res.error_phase == pdfr_pkg::PH_LEAD_PULSE &&
         o_res.frame_end == (o_res.byte_index == LAST_POS)))
        else $error("frame end does not match byte position");

    // Checksum flag only on the last byte
    a_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.frame_end) |-> !o_res.checksum_ok)
        else $error("checksum flag outside frame end");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=>
        (o_res.valid && $stable(o_res.data_byte) && $stable(o_res.kind) &&
         $stable(o_res.byte_index)))
        else $error("stalled result changed");

endmodule

bind pulse_distance_frame_receiver pdfr_checker #(
    .FRAME_BYTES(FRAME_BYTES)
) u_pdfr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_res   (o_res)
);
